// ===== rtl/prt_pkg.sv =====
// ----------------------------------------------------------------------------
// prt_pkg: shared types and constants of the probe RTT monitor
// Holds the command word passed from front to back, the slot layout, the
// result word, opcodes, register indexes and state machine encodings.
// ----------------------------------------------------------------------------
package prt_pkg;

  // Input opcodes
  localparam logic [1:0] OP_SEND  = 2'd0;
  localparam logic [1:0] OP_ECHO  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Configuration register indexes
  localparam logic CFG_PAUSED     = 1'b0;
  localparam logic CFG_LOSS_LIMIT = 1'b1;

  localparam logic [15:0] LOSS_LIMIT_RST = 16'd20;
  localparam logic [19:0] RTT_CLAMP      = 20'd999999;
  localparam logic [19:0] MIN_NONE       = 20'hFFFFF;
  localparam logic [31:0] SEQ_FIRST      = 32'd1;
  localparam logic [31:0] SEQ_LAST       = 32'hFFFFFFFF;

  // Remainder unit: digits per cycle and number of cycles for a 32-bit number
  localparam int MOD_BITS  = 4;
  localparam int MOD_STEPS = 32 / MOD_BITS;
  localparam int MOD_CW    = $clog2(MOD_STEPS);

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    CMD_NOP,
    CMD_SEND,
    CMD_ECHO,
    CMD_CLEAR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [31:0] seq;
    logic [63:0] now;
    logic        ok;
  } cmd_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] tag;
    logic [63:0] stamp;
  } slot_t;

  typedef struct packed {
    logic        sent_valid;
    logic [31:0] sent_seq;
    logic        sample_valid;
    logic [19:0] last_rtt;
    logic [19:0] min_rtt;
    logic [19:0] max_rtt;
    logic [63:0] rtt_sum;
    logic [31:0] tx_total;
    logic [31:0] rx_total;
    logic [31:0] loss;
    logic        loss_alarm;
  } result_t;

  typedef enum logic {
    FR_IDLE,
    FR_MOD
  } front_state_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CALC,
    BK_DONE,
    BK_SWEEP
  } back_state_t;

endpackage

// ===== rtl/probe_rtt_monitor.sv =====
// ----------------------------------------------------------------------------
// probe_rtt_monitor: round-trip latency monitor for sequence-numbered probes
// Send, echo and clear words in; one result word out per input word.
// A send or echo passes the queue, the table read and BK_CALC; its result is
//   registered in BK_DONE once the result channel is free. An echo first takes
//   its slot index from the 4-bit-a-cycle remainder unit, with in_stall high,
//   when TABLE_DEPTH is not a power of two. A send is written to the table in
//   BK_CALC; BK_DONE may read the next send or echo. A clear gives its result,
//   then sweeps every slot. Reset: synchronous, active low; the table is swept
//   with in_stall high; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module probe_rtt_monitor
  import prt_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [31:0] in_echo_seq,
  input  logic [63:0] in_now_us,
  input  logic        in_send_ok,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_sent_valid,
  output logic [31:0] out_sent_seq,
  output logic        out_sample_valid,
  output logic [19:0] out_last_rtt,
  output logic [19:0] out_min_rtt,
  output logic [19:0] out_max_rtt,
  output logic [63:0] out_rtt_sum,
  output logic [31:0] out_tx_total,
  output logic [31:0] out_rx_total,
  output logic [31:0] out_loss,
  output logic        out_loss_alarm
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int QW = $bits(cmd_t) + IW;

  logic          paused_r, paused_nxt;
  logic [15:0]   loss_limit_r, loss_limit_nxt;

  logic          q_push, q_pop, q_empty, q_full;
  logic [QW-1:0] q_wdata, q_head;
  logic          sweeping;

  logic                     ram_we, ram_re;
  logic [IW-1:0]            ram_waddr, ram_raddr;
  logic [$bits(slot_t)-1:0] ram_wdata, ram_rdata;
  result_t                  result;

  // Configuration registers: the front reads paused, the back loss_limit
  always_comb begin
    paused_nxt     = paused_r;
    loss_limit_nxt = loss_limit_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_PAUSED:     paused_nxt     = cfg_wdata[0];
        CFG_LOSS_LIMIT: loss_limit_nxt = cfg_wdata;
        default: begin
          paused_nxt = paused_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      paused_r     <= 1'b0;
      loss_limit_r <= LOSS_LIMIT_RST;
    end else begin
      paused_r     <= paused_nxt;
      loss_limit_r <= loss_limit_nxt;
    end
  end

  // Front: accept words, assign sequence numbers, find the echo's slot
  prt_front #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_op      (in_op),
    .in_echo_seq(in_echo_seq),
    .in_now_us  (in_now_us),
    .in_send_ok (in_send_ok),
    .paused     (paused_r),
    .sweeping   (sweeping),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_wdata    (q_wdata)
  );

  // Queue: decouple the front from the table accesses
  prt_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .wdata(q_wdata),
    .pop  (q_pop),
    .head (q_head),
    .empty(q_empty),
    .full (q_full)
  );

  // Back: table read, match, write-back and statistics
  prt_back #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .loss_limit(loss_limit_r),
    .sweeping  (sweeping),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .result    (result)
  );

  // Slot table: valid mark, tag and send time per slot
  prt_ram #(
    .WIDTH($bits(slot_t)),
    .DEPTH(TABLE_DEPTH)
  ) u_slot_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Unpack the result word onto the output ports
  assign out_sent_valid   = result.sent_valid;
  assign out_sent_seq     = result.sent_seq;
  assign out_sample_valid = result.sample_valid;
  assign out_last_rtt     = result.last_rtt;
  assign out_min_rtt      = result.min_rtt;
  assign out_max_rtt      = result.max_rtt;
  assign out_rtt_sum      = result.rtt_sum;
  assign out_tx_total     = result.tx_total;
  assign out_rx_total     = result.rx_total;
  assign out_loss         = result.loss;
  assign out_loss_alarm   = result.loss_alarm;

endmodule

// ===== rtl/prt_ram.sv =====
// ----------------------------------------------------------------------------
// prt_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module prt_ram #(
  parameter int WIDTH = 97,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/prt_queue.sv =====
// ----------------------------------------------------------------------------
// prt_queue: short command queue between front and back
// Two-entry FIFO; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module prt_queue
  import prt_pkg::*;
#(
  parameter int WIDTH = 109
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             empty,
  output logic             full
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] entry_r [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wdata;
    end
  end

  assign head  = entry_r[rd_ptr_r];
  assign empty = (count_r == '0);
  assign full  = (count_r == CW'(QUEUE_DEPTH));

endmodule

// ===== rtl/prt_front.sv =====
// ----------------------------------------------------------------------------
// prt_front: input side of the probe RTT monitor
// Accepts words, assigns sequence numbers and slot indexes, finds the slot of
// an echo and pushes one command per word into the queue.
// ----------------------------------------------------------------------------
module prt_front
  import prt_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_op,
  input  logic [31:0]                    in_echo_seq,
  input  logic [63:0]                    in_now_us,
  input  logic                           in_send_ok,
  input  logic                           paused,
  input  logic                           sweeping,
  input  logic                           q_full,
  output logic                           q_push,
  output logic [$bits(cmd_t)+$clog2(TABLE_DEPTH)-1:0] q_wdata
);

  localparam int  IW   = $clog2(TABLE_DEPTH);
  localparam bit  POW2 = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;
  localparam logic [IW:0]   DEPTH_W  = (IW + 1)'(TABLE_DEPTH);
  localparam logic [IW-1:0] IDX_LAST = IW'(TABLE_DEPTH - 1);
  localparam logic [IW-1:0] IDX_FIRST = IW'(1);

  front_state_t      state_r, state_nxt;
  logic [31:0]       next_seq_r, next_seq_nxt;
  logic [IW-1:0]     next_idx_r, next_idx_nxt;
  cmd_t              hold_r, hold_nxt;
  logic [31:0]       x_r, x_nxt;
  logic [IW-1:0]     rem_r, rem_nxt;
  logic [MOD_CW-1:0] cnt_r, cnt_nxt;
  logic [IW-1:0]     rem_step;
  logic              accept;
  cmd_t              push_cmd;
  logic [IW-1:0]     push_idx;

  assign in_stall = (state_r != FR_IDLE) || q_full || sweeping;
  assign accept   = in_valid && !in_stall;

  // Four restoring remainder steps on the top digits of the shifting echo
  always_comb begin
    logic [IW:0] r;
    r = {1'b0, rem_r};
    for (int i = 0; i < MOD_BITS; i++) begin
      r = {r[IW-1:0], x_r[31 - i]};
      if (r >= DEPTH_W) begin
        r = r - DEPTH_W;
      end
    end
    rem_step = r[IW-1:0];
  end

  always_comb begin
    state_nxt    = state_r;
    next_seq_nxt = next_seq_r;
    next_idx_nxt = next_idx_r;
    hold_nxt     = hold_r;
    x_nxt        = x_r;
    rem_nxt      = rem_r;
    cnt_nxt      = cnt_r;
    q_push       = 1'b0;
    push_cmd     = '{kind: CMD_NOP, seq: in_echo_seq, now: in_now_us, ok: in_send_ok};
    push_idx     = '0;

    case (state_r)
      FR_IDLE: begin
        if (accept) begin
          case (in_op)
            OP_SEND: begin
              q_push = 1'b1;
              if (!paused) begin
                push_cmd.kind = CMD_SEND;
                push_cmd.seq  = next_seq_r;
                push_idx      = next_idx_r;
                next_seq_nxt  = next_seq_r + 1'b1;
                // the number after the last wraps to zero, whose slot is zero
                if (next_seq_r == SEQ_LAST || next_idx_r == IDX_LAST) begin
                  next_idx_nxt = '0;
                end else begin
                  next_idx_nxt = next_idx_r + 1'b1;
                end
              end
            end
            OP_ECHO: begin
              if (POW2) begin
                q_push        = 1'b1;
                push_cmd.kind = CMD_ECHO;
                push_idx      = in_echo_seq[IW-1:0];
              end else begin
                hold_nxt      = push_cmd;
                hold_nxt.kind = CMD_ECHO;
                x_nxt         = in_echo_seq;
                rem_nxt       = '0;
                cnt_nxt       = '0;
                state_nxt     = FR_MOD;
              end
            end
            OP_CLEAR: begin
              q_push        = 1'b1;
              push_cmd.kind = CMD_CLEAR;
              next_seq_nxt  = SEQ_FIRST;
              next_idx_nxt  = IDX_FIRST;
            end
            default: begin
              q_push = 1'b1;
            end
          endcase
        end
      end
      FR_MOD: begin
        x_nxt   = x_r << MOD_BITS;
        rem_nxt = rem_step;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == MOD_CW'(MOD_STEPS - 1)) begin
          q_push    = 1'b1;
          push_cmd  = hold_r;
          push_idx  = rem_step;
          state_nxt = FR_IDLE;
        end
      end
      default: begin
        state_nxt = FR_IDLE;
      end
    endcase
  end

  assign q_wdata = {push_cmd, push_idx};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= FR_IDLE;
      next_seq_r <= SEQ_FIRST;
      next_idx_r <= IDX_FIRST;
      cnt_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      next_seq_r <= next_seq_nxt;
      next_idx_r <= next_idx_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
    x_r    <= x_nxt;
    rem_r  <= rem_nxt;
  end

endmodule

// ===== rtl/prt_back.sv =====
// ----------------------------------------------------------------------------
// prt_back: execution side of the probe RTT monitor
// Pops commands, reads and writes the slot table, keeps the statistics,
// sweeps the table after reset and clear, and holds the result word.
// ----------------------------------------------------------------------------
module prt_back
  import prt_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [$bits(cmd_t)+$clog2(TABLE_DEPTH)-1:0] q_head,
  input  logic                           q_empty,
  output logic                           q_pop,
  input  logic [15:0]                    loss_limit,
  output logic                           sweeping,
  output logic                           ram_we,
  output logic [$clog2(TABLE_DEPTH)-1:0] ram_waddr,
  output logic [$bits(slot_t)-1:0]       ram_wdata,
  output logic                           ram_re,
  output logic [$clog2(TABLE_DEPTH)-1:0] ram_raddr,
  input  logic [$bits(slot_t)-1:0]       ram_rdata,
  output logic                           out_valid,
  input  logic                           out_stall,
  output result_t                        result
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam logic [IW-1:0] IDX_LAST = IW'(TABLE_DEPTH - 1);

  back_state_t   state_r, state_nxt;
  cmd_t          cur_r, cur_nxt;
  logic [IW-1:0] sweep_r, sweep_nxt;
  logic          hit_r, hit_nxt;
  logic [19:0]   rtt_r, rtt_nxt;
  logic [19:0]   last_r, last_nxt;
  logic [19:0]   min_r, min_nxt;
  logic [19:0]   max_r, max_nxt;
  logic [63:0]   sum_r, sum_nxt;
  logic [31:0]   tx_r, tx_nxt;
  logic [31:0]   rx_r, rx_nxt;
  logic          out_valid_r, out_valid_nxt;
  result_t       res_r, res_nxt, res_build;

  cmd_t          head_cmd;
  logic [IW-1:0] head_idx;
  slot_t         rd_slot;
  logic          out_free;
  logic          load;
  logic          sent_v;
  logic          sample_v;
  logic [63:0]   diff;
  logic [31:0]   loss_c;

  assign head_cmd = cmd_t'(q_head[$bits(q_head)-1:IW]);
  assign head_idx = q_head[IW-1:0];
  assign rd_slot  = slot_t'(ram_rdata);
  assign out_free = !out_valid_r || !out_stall;
  assign diff     = cur_r.now - rd_slot.stamp;

  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    sweep_nxt = sweep_r;
    hit_nxt   = hit_r;
    rtt_nxt   = rtt_r;
    last_nxt  = last_r;
    min_nxt   = min_r;
    max_nxt   = max_r;
    sum_nxt   = sum_r;
    tx_nxt    = tx_r;
    rx_nxt    = rx_r;
    q_pop     = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = cur_r.seq[IW-1:0];
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = head_idx;
    load      = 1'b0;
    sent_v    = 1'b0;
    sample_v  = 1'b0;

    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          if (head_cmd.kind == CMD_CLEAR) begin
            if (out_free) begin
              q_pop     = 1'b1;
              load      = 1'b1;
              last_nxt  = '0;
              min_nxt   = MIN_NONE;
              max_nxt   = '0;
              sum_nxt   = '0;
              tx_nxt    = '0;
              rx_nxt    = '0;
              sweep_nxt = '0;
              state_nxt = BK_SWEEP;
            end
          end else begin
            q_pop     = 1'b1;
            ram_re    = 1'b1;
            cur_nxt   = head_cmd;
            sweep_nxt = head_idx;
            state_nxt = BK_CALC;
          end
        end
      end
      BK_CALC: begin
        hit_nxt = (cur_r.kind == CMD_ECHO) && rd_slot.valid && (rd_slot.tag == cur_r.seq);
        rtt_nxt = (diff > 64'(RTT_CLAMP)) ? RTT_CLAMP : diff[19:0];
        if (cur_r.kind == CMD_SEND) begin
          ram_we    = 1'b1;
          ram_waddr = sweep_r;
          ram_wdata = slot_t'{valid: 1'b1, tag: cur_r.seq, stamp: cur_r.now};
          if (cur_r.ok) begin
            tx_nxt = tx_r + 1'b1;
          end
        end
        if (hit_nxt) begin
          rx_nxt = rx_r + 1'b1;
        end
        state_nxt = BK_DONE;
      end
      BK_DONE: begin
        if (out_free) begin
          load     = 1'b1;
          sent_v   = (cur_r.kind == CMD_SEND);
          sample_v = hit_r;
          if (hit_r) begin
            last_nxt = rtt_r;
            sum_nxt  = sum_r + 64'(rtt_r);
            if (rtt_r < min_r) begin
              min_nxt = rtt_r;
            end
            if (rtt_r > max_r) begin
              max_nxt = rtt_r;
            end
          end
          // chain straight into the next table access when a command other than a clear is waiting
          if (!q_empty && head_cmd.kind != CMD_CLEAR) begin
            q_pop     = 1'b1;
            ram_re    = 1'b1;
            cur_nxt   = head_cmd;
            sweep_nxt = head_idx;
            state_nxt = BK_CALC;
          end else begin
            state_nxt = BK_IDLE;
          end
        end
      end
      BK_SWEEP: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_r;
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == IDX_LAST) begin
          sweep_nxt = '0;
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // Result word from the statistics after the current command
  always_comb begin
    loss_c                 = (tx_nxt > rx_nxt) ? tx_nxt - rx_nxt : '0;
    res_build.sent_valid   = sent_v;
    res_build.sent_seq     = sent_v ? cur_r.seq : '0;
    res_build.sample_valid = sample_v;
    res_build.last_rtt     = last_nxt;
    res_build.min_rtt      = (min_nxt == MIN_NONE) ? '0 : min_nxt;
    res_build.max_rtt      = max_nxt;
    res_build.rtt_sum      = sum_nxt;
    res_build.tx_total     = tx_nxt;
    res_build.rx_total     = rx_nxt;
    res_build.loss         = loss_c;
    res_build.loss_alarm   = loss_c > 32'(loss_limit);
  end

  always_comb begin
    res_nxt       = load ? res_build : res_r;
    out_valid_nxt = load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_SWEEP;
      sweep_r     <= '0;
      hit_r       <= 1'b0;
      last_r      <= '0;
      min_r       <= MIN_NONE;
      max_r       <= '0;
      sum_r       <= '0;
      tx_r        <= '0;
      rx_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      hit_r       <= hit_nxt;
      last_r      <= last_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      sum_r       <= sum_nxt;
      tx_r        <= tx_nxt;
      rx_r        <= rx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    rtt_r <= rtt_nxt;
    res_r <= res_nxt;
  end

  assign sweeping  = (state_r == BK_SWEEP);
  assign out_valid = out_valid_r;
  assign result    = res_r;

endmodule
